@@ rtl/core/akt_pkg.sv @@
// ----------------------------------------------------------------------------
// akt_pkg: shared types and constants of the active key timeout table
// Holds the function codes, the classified command that passes from the front
// part to the back part, and the table and queue dimensions.
// ----------------------------------------------------------------------------
package akt_pkg;

  // Table and result limits.
  localparam int SLOTS_DEF     = 5;
  localparam int MAX_RESULTS   = 5;
  localparam int CNT_W         = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd60;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Function codes of an input item.
  localparam logic [1:0] FUNC_PRESS   = 2'd0;
  localparam logic [1:0] FUNC_SCAN    = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // Classified operation.
  typedef enum logic [2:0] {
    OP_PRESS,
    OP_PRESS_NULL,
    OP_SCAN,
    OP_REFRESH,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] key;
    logic [7:0] now;
  } cmd_t;

endpackage

@@ rtl/core/akt_front.sv @@
// ----------------------------------------------------------------------------
// akt_front: item intake and command queue
// Classifies each accepted item into an operation and holds it in a short
// queue until the back part takes it.
// ----------------------------------------------------------------------------
module akt_front import akt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] func,
  input  logic [7:0] sender_addr,
  input  logic [7:0] key_number,
  input  logic [7:0] now_ms,
  output cmd_t       q_cmd,
  output logic       q_valid,
  input  logic       q_pop
);

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  always_comb begin
    cmd_in.addr = sender_addr;
    cmd_in.key  = key_number;
    cmd_in.now  = now_ms;
    unique case (func)
      FUNC_PRESS:   cmd_in.op = (sender_addr == 8'd0) ? OP_PRESS_NULL : OP_PRESS;
      FUNC_SCAN:    cmd_in.op = OP_SCAN;
      FUNC_REFRESH: cmd_in.op = OP_REFRESH;
      default:      cmd_in.op = OP_NOP;
    endcase
  end

  assign item_stall = (count == CNT_FULL);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != '0);
  assign pop        = q_pop && q_valid;
  assign q_cmd      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

@@ rtl/core/akt_back.sv @@
// ----------------------------------------------------------------------------
// akt_back: key table and command sequencer
// Holds the slot table and carries out one command at a time, visiting one
// slot per cycle while no release is stalled, and drives the result register.
// ----------------------------------------------------------------------------
module akt_back import akt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       q_cmd,
  input  logic       q_valid,
  output logic       q_pop,
  input  logic [7:0] timeout_ms,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_new,
  output logic       released,
  output logic [7:0] rel_addr,
  output logic [7:0] rel_key,
  output logic       last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_FINAL = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRESS,
    S_SCAN_MASK,
    S_SCAN,
    S_REFRESH,
    S_FINISH
  } state_t;

  state_t           state;
  cmd_t             cmd;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] empty_idx;
  logic [SLOTS-1:0] mask;
  logic [CNT_W-1:0] rel_cnt;
  logic             res_new;

  logic [7:0] slot_addr  [SLOTS];
  logic [7:0] slot_key   [SLOTS];
  logic [7:0] slot_stamp [SLOTS];

  logic [7:0]       cur_addr;
  logic [7:0]       cur_key;
  logic             cur_match;
  logic             out_free;
  logic [SLOTS-1:0] expired;
  logic [SLOTS-1:0] mask_rest;
  logic             scan_last;

  logic             addr_we;
  logic             key_we;
  logic             stamp_we;
  logic [IDX_W-1:0] widx;
  logic [7:0]       addr_wdata;

  assign cur_addr  = slot_addr[idx];
  assign cur_key   = slot_key[idx];
  assign cur_match = (cur_addr != 8'd0) && (cur_addr == cmd.addr) && (cur_key == cmd.key);
  assign out_free  = !result_valid || !result_stall;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mask_rest = mask & ~(SLOTS'(1) << idx);
  assign scan_last = (rel_cnt == CNT_FINAL) || (mask_rest == '0);

  // Expiry test of every slot against the scan's time stamp.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      expired[i] = (slot_addr[i] != 8'd0) &&
                   (8'(cmd.now - slot_stamp[i]) > timeout_ms);
    end
  end

  // Table write control for the slot under the sequencer.
  always_comb begin
    addr_we    = 1'b0;
    key_we     = 1'b0;
    stamp_we   = 1'b0;
    widx       = idx;
    addr_wdata = cmd.addr;
    unique case (state)
      S_PRESS: begin
        if (cur_match) begin
          stamp_we = 1'b1;
        end else if (idx == LAST_IDX) begin
          widx     = (cur_addr == 8'd0) ? idx : empty_idx;
          addr_we  = 1'b1;
          key_we   = 1'b1;
          stamp_we = 1'b1;
        end
      end
      S_SCAN: begin
        if (mask[idx] && out_free) begin
          addr_we    = 1'b1;
          addr_wdata = 8'd0;
        end
      end
      S_REFRESH: begin
        stamp_we = (cur_addr != 8'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_addr[i] <= 8'd0;
      end
    end else if (addr_we) begin
      slot_addr[widx] <= addr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      slot_key[widx] <= cmd.key;
    end
    if (stamp_we) begin
      slot_stamp[widx] <= cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd       <= q_cmd;
            idx       <= '0;
            empty_idx <= '0;
            rel_cnt   <= '0;
            res_new   <= 1'b0;
            unique case (q_cmd.op)
              OP_PRESS:   state <= S_PRESS;
              OP_SCAN:    state <= S_SCAN_MASK;
              OP_REFRESH: state <= S_REFRESH;
              default:    state <= S_FINISH;
            endcase
          end
        end
        S_PRESS: begin
          if (cur_match) begin
            res_new <= 1'b0;
            state   <= S_FINISH;
          end else begin
            if (cur_addr == 8'd0) begin
              empty_idx <= idx;
            end
            if (idx == LAST_IDX) begin
              res_new <= 1'b1;
              state   <= S_FINISH;
            end else begin
              idx <= IDX_W'(idx + 1'b1);
            end
          end
        end
        S_SCAN_MASK: begin
          mask <= expired;
          if (expired == '0) begin
            state <= S_FINISH;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mask[idx]) begin
            if (out_free) begin
              result_valid <= 1'b1;
              is_new       <= 1'b0;
              released     <= 1'b1;
              rel_addr     <= cur_addr;
              rel_key      <= cur_key;
              last         <= scan_last;
              mask         <= mask_rest;
              rel_cnt      <= CNT_W'(rel_cnt + 1'b1);
              if (scan_last) begin
                state <= S_IDLE;
              end else if (idx != LAST_IDX) begin
                idx <= IDX_W'(idx + 1'b1);
              end
            end
          end else if (idx != LAST_IDX) begin
            idx <= IDX_W'(idx + 1'b1);
          end
        end
        S_REFRESH: begin
          if (idx == LAST_IDX) begin
            state <= S_FINISH;
          end else begin
            idx <= IDX_W'(idx + 1'b1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            is_new       <= res_new;
            released     <= 1'b0;
            rel_addr     <= 8'd0;
            rel_key      <= 8'd0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only a scan gives more than one result, so a result that is not the last
  // one must carry a release.
  a_multi_only_scan: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> released)
    else $error("non-final result without a release");

  // A release never reports an empty slot.
  a_release_addr: assert property (@(posedge clk) disable iff (rst)
    (result_valid && released) |-> (rel_addr != 8'd0))
    else $error("release of an empty slot");

  // A result is either a press answer or a release, never both.
  a_new_vs_release: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(is_new && released))
    else $error("result flags both new key and release");

  // A command is taken from the queue only when the last result of the
  // previous one has been loaded.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != S_IDLE))
    else $error("command taken but sequencer stayed idle");

endmodule

@@ rtl/core/active_key_timeout_table.sv @@
// ----------------------------------------------------------------------------
// active_key_timeout_table: table of held keys with timeout release
// Top level: timeout register, item intake and queue, table sequencer.
// ----------------------------------------------------------------------------
// The block keeps a table of SLOTS keys that are currently held, each entry
// holding a sender address, a key number and an 8-bit millisecond stamp; an
// address of zero marks an empty slot. A press item refreshes the stamp of a
// matching entry or stores the key in the highest-numbered empty slot
// (slot 0 is overwritten when the table is full) and gives one result whose
// is_new says whether the key was new. A scan item gives one result per entry
// whose wrapped age exceeds timeout_ms, in slot order and at most MAX_RESULTS
// of them, clearing each released entry; without expiry it gives a single
// result with released low. A refresh item restamps every active entry. Each
// item's final result has last set. Items enter a two-entry queue, so intake
// goes on while the table sequencer works and while a result waits on
// result_stall. The sequencer visits one slot per cycle, save that a scan
// holds on an expired slot while its release waits on result_stall. A press
// ends its walk at a matching slot, a scan at its last released entry and a
// refresh at the last slot; a scan without expiry, a press with address zero
// and an unused code skip the walk. The timeout register resets to 60 and is
// written through cfg_valid/cfg_ready, which is always ready; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module active_key_timeout_table import akt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // Input item channel.
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] func,
  input  logic [7:0] sender_addr,
  input  logic [7:0] key_number,
  input  logic [7:0] now_ms,
  // Result item channel.
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_new,
  output logic       released,
  output logic [7:0] rel_addr,
  output logic [7:0] rel_key,
  output logic       last
);

  logic [7:0] timeout_ms;
  cmd_t       q_cmd;
  logic       q_valid;
  logic       q_pop;

  // The register is a single byte and can always be written.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ms <= cfg_data;
    end
  end

  // Front part: classifies every accepted item and queues it.
  akt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .func        (func),
    .sender_addr (sender_addr),
    .key_number  (key_number),
    .now_ms      (now_ms),
    .q_cmd       (q_cmd),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  // Back part: owns the table and works through one command at a time.
  akt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_cmd        (q_cmd),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .timeout_ms   (timeout_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_new       (is_new),
    .released     (released),
    .rel_addr     (rel_addr),
    .rel_key      (rel_key),
    .last         (last)
  );

endmodule

@@ verif/akt_checker.sv @@
// ----------------------------------------------------------------------------
// akt_checker: result checker for the active key timeout table
// Watches the configuration, item and result channels, keeps its own copy of
// the held key table, and compares every accepted result with the oldest one
// owed. The running error count and the number of owed results go out to the
// testbench top.
// ----------------------------------------------------------------------------
module akt_checker import akt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  input  logic       item_stall,
  input  logic [1:0] func,
  input  logic [7:0] sender_addr,
  input  logic [7:0] key_number,
  input  logic [7:0] now_ms,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic       is_new,
  input  logic       released,
  input  logic [7:0] rel_addr,
  input  logic [7:0] rel_key,
  input  logic       last,
  output int         errors,
  output int         outstanding
);

  typedef struct packed {
    logic       is_new;
    logic       released;
    logic [7:0] addr;
    logic [7:0] key;
    logic       last;
  } key_event_t;

  logic [7:0] hold_timeout;
  logic [7:0] held_addr  [SLOTS];
  logic [7:0] held_key   [SLOTS];
  logic [7:0] held_stamp [SLOTS];
  key_event_t owed_events [$];
  int         error_count = 0;

  function automatic key_event_t key_event(logic n, logic r, logic [7:0] a,
                                           logic [7:0] k, logic l);
    key_event_t ev;
    ev.is_new   = n;
    ev.released = r;
    ev.addr     = a;
    ev.key      = k;
    ev.last     = l;
    return ev;
  endfunction

  // Works out the results of one item and updates the table copy.
  task automatic apply_key_item(input logic [1:0] f, input logic [7:0] a,
                                input logic [7:0] k, input logic [7:0] t);
    int         i;
    int         free_slot;
    bit         hit;
    int         fired;
    logic [7:0] age;
    key_event_t held_back;
    free_slot = 0;
    hit       = 1'b0;
    fired     = 0;
    held_back = key_event(1'b0, 1'b0, 8'd0, 8'd0, 1'b0);
    case (f)
      FUNC_PRESS: begin
        if (a == 8'd0) begin
          owed_events.push_back(key_event(1'b0, 1'b0, 8'd0, 8'd0, 1'b1));
        end else begin
          for (i = 0; i < SLOTS && !hit; i++) begin
            if (held_addr[i] == 8'd0) begin
              free_slot = i;
            end else if (held_addr[i] == a && held_key[i] == k) begin
              hit           = 1'b1;
              held_stamp[i] = t;
            end
          end
          if (!hit) begin
            held_addr[free_slot]  = a;
            held_key[free_slot]   = k;
            held_stamp[free_slot] = t;
          end
          owed_events.push_back(key_event(!hit, 1'b0, 8'd0, 8'd0, 1'b1));
        end
      end
      FUNC_SCAN: begin
        // The previous release is held back until it is known whether another
        // follows, so that only the final one carries last.
        for (i = 0; i < SLOTS && fired < MAX_RESULTS; i++) begin
          age = t - held_stamp[i];
          if (held_addr[i] != 8'd0 && age > hold_timeout) begin
            if (fired != 0) owed_events.push_back(held_back);
            held_back    = key_event(1'b0, 1'b1, held_addr[i], held_key[i], 1'b0);
            held_addr[i] = 8'd0;
            fired++;
          end
        end
        if (fired == 0) begin
          owed_events.push_back(key_event(1'b0, 1'b0, 8'd0, 8'd0, 1'b1));
        end else begin
          held_back.last = 1'b1;
          owed_events.push_back(held_back);
        end
      end
      FUNC_REFRESH: begin
        for (i = 0; i < SLOTS; i++) begin
          if (held_addr[i] != 8'd0) held_stamp[i] = t;
        end
        owed_events.push_back(key_event(1'b0, 1'b0, 8'd0, 8'd0, 1'b1));
      end
      default: begin
        owed_events.push_back(key_event(1'b0, 1'b0, 8'd0, 8'd0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    key_event_t want;
    if (rst) begin
      hold_timeout = TIMEOUT_RESET;
      for (int i = 0; i < SLOTS; i++) held_addr[i] = 8'd0;
      owed_events.delete();
    end else begin
      // Results are checked before the item of this edge is taken in, so a
      // stray result can never be matched against its own item.
      if (result_valid && !result_stall) begin
        if (owed_events.size() == 0) begin
          $display("%0t: result with none expected, got new %0b rel %0b %0d/%0d last %0b",
                   $time, is_new, released, rel_addr, rel_key, last);
          error_count++;
        end else begin
          want = owed_events.pop_front();
          check_field("is_new", want.is_new, is_new);
          check_field("released", want.released, released);
          check_field("rel_addr", want.addr, rel_addr);
          check_field("rel_key", want.key, rel_key);
          check_field("last", want.last, last);
        end
      end
      if (cfg_valid && cfg_ready) hold_timeout = cfg_data;
      if (item_valid && !item_stall) begin
        apply_key_item(func, sender_addr, key_number, now_ms);
      end
    end
    errors      <= error_count;
    outstanding <= owed_events.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top of the active key timeout table
// Drives a directed run through presses, scans, refreshes and the unused code,
// then random phases under several timeout settings, with random gaps on the
// item side and random stalls on the result side. A checker module beside the
// block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb import akt_pkg::*; ();

  // The fourth function code is not named in the package; the block must
  // treat it as a no-operation.
  localparam logic [1:0] FUNC_UNUSED     = 2'd3;
  localparam int         RANDOM_PHASES   = 6;
  localparam int         ITEMS_PER_PHASE = 24;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data     = 8'd0;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic [1:0] func         = FUNC_PRESS;
  logic [7:0] sender_addr  = 8'd0;
  logic [7:0] key_number   = 8'd0;
  logic [7:0] now_ms       = 8'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       is_new;
  logic       released;
  logic [7:0] rel_addr;
  logic [7:0] rel_key;
  logic       last;
  int         errors;
  int         outstanding;

  // While calm is set neither side idles, which gives stretches at full rate.
  bit         calm         = 1'b0;
  int         stall_left   = 0;
  logic [7:0] ms_clock     = 8'd0;
  logic [7:0] phase_timeout [RANDOM_PHASES] = '{8'd40, 8'd0, 8'd255, 8'd1, 8'd120, 8'd60};

  active_key_timeout_table #(.SLOTS(SLOTS_DEF)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .func(func),
    .sender_addr(sender_addr), .key_number(key_number), .now_ms(now_ms),
    .result_valid(result_valid), .result_stall(result_stall), .is_new(is_new),
    .released(released), .rel_addr(rel_addr), .rel_key(rel_key), .last(last)
  );

  akt_checker #(.SLOTS(SLOTS_DEF)) watcher (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .func(func),
    .sender_addr(sender_addr), .key_number(key_number), .now_ms(now_ms),
    .result_valid(result_valid), .result_stall(result_stall), .is_new(is_new),
    .released(released), .rel_addr(rel_addr), .rel_key(rel_key), .last(last),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The run is ended here if the block stops answering.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Idle span in cycles: mostly none or a few, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side alternates between runs of acceptance and runs of stall.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      result_stall <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      result_stall <= 1'b1;
      stall_left   <= idle_span();
    end
  end

  // Offers one item after an optional gap and holds it until it is taken.
  // Valid stays high after acceptance, so back-to-back items need no gap and
  // valid is never dropped and raised within the same time step.
  task automatic send_item(input logic [1:0] f, input logic [7:0] a,
                           input logic [7:0] k, input logic [7:0] t);
    int gap;
    gap = idle_span();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    func        <= f;
    sender_addr <= a;
    key_number  <= k;
    now_ms      <= t;
    do @(posedge clk); while (item_stall);
  endtask

  // Stops offering items and waits until every owed result has come back.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // The timeout register is only written once the block is idle.
  task automatic write_timeout(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] addr_pool [3];
    logic [7:0] a;
    logic [7:0] k;
    logic [1:0] f;
    int         r;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the timeout at its reset value of 60.
    // A press with address zero is never stored, and a scan or a refresh of
    // the empty table gives a single plain result; the unused code does nothing.
    send_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_REFRESH, 8'd0, 8'd0, 8'd5);
    send_item(FUNC_UNUSED, 8'd255, 8'd255, 8'd255);

    // Fill the table from the top slot down, pressing one key twice, then
    // press one more key so that slot 0 is overwritten.
    send_item(FUNC_PRESS, 8'd255, 8'd255, 8'd250);
    send_item(FUNC_PRESS, 8'd255, 8'd255, 8'd252);
    send_item(FUNC_PRESS, 8'd1, 8'd0, 8'd252);
    send_item(FUNC_PRESS, 8'd2, 8'd128, 8'd253);
    send_item(FUNC_PRESS, 8'd3, 8'd1, 8'd254);
    send_item(FUNC_PRESS, 8'd128, 8'd254, 8'd255);
    send_item(FUNC_PRESS, 8'd7, 8'd7, 8'd0);

    // Ages wrap across zero here: first the two oldest entries sit exactly at
    // the timeout, one millisecond later those two go.
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd56);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd57);

    // A refresh restamps the rest, which then expire together.
    send_item(FUNC_REFRESH, 8'd0, 8'd0, 8'd100);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd160);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd161);

    // A full table released in one scan gives the largest number of results.
    send_item(FUNC_PRESS, 8'h55, 8'hAA, 8'd10);
    send_item(FUNC_PRESS, 8'hAA, 8'h55, 8'd11);
    send_item(FUNC_PRESS, 8'h0F, 8'hF0, 8'd12);
    send_item(FUNC_PRESS, 8'hF0, 8'h0F, 8'd13);
    send_item(FUNC_PRESS, 8'h80, 8'h01, 8'd14);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd200);

    // With a zero timeout any age of one or more releases the key.
    write_timeout(8'd0);
    send_item(FUNC_PRESS, 8'd9, 8'd9, 8'd50);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd50);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd51);

    // With the largest timeout no age can ever exceed it.
    write_timeout(8'd255);
    send_item(FUNC_PRESS, 8'd9, 8'd9, 8'd0);
    send_item(FUNC_SCAN, 8'd0, 8'd0, 8'd255);

    // Random phases. Each phase uses its own small set of addresses and few
    // key numbers, so that repeated presses hit existing entries, and time
    // mostly creeps forward with the odd large jump to let keys expire.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_timeout(phase == 2 ? 8'($urandom_range(0, 255)) : phase_timeout[phase]);
      calm = (phase == 3);
      for (int j = 0; j < 3; j++) addr_pool[j] = 8'($urandom_range(1, 255));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) f = FUNC_PRESS;
        else if (r < 85) f = FUNC_SCAN;
        else if (r < 95) f = FUNC_REFRESH;
        else f = FUNC_UNUSED;
        // Now and then a fully random address, zero included.
        if ($urandom_range(0, 9) < 7) a = addr_pool[$urandom_range(0, 2)];
        else a = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) k = 8'($urandom_range(0, 3));
        else k = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) ms_clock = ms_clock + 8'($urandom_range(0, 10));
        else ms_clock = ms_clock + 8'($urandom_range(20, 150));
        send_item(f, a, k, ms_clock);
      end
    end
    calm = 1'b0;

    // Let everything owed come back, then give a stray result time to show.
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
